// ===== rtl/core/text_terminal_engine_macros.svh =====
// Assertion macros for the text terminal engine.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef TEXT_TERMINAL_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tte_pkg.sv =====
// Shared types, constants and helpers for the text terminal engine.
// No dependencies; used by tte_seq and text_terminal_engine.
package tte_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Field and storage widths
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CUR_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int FILL_IW = $clog2(ROWS);
    localparam int LIN_W   = ROW_W + COL_W + 1;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BKSP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    // Cell value after reset: grey space
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } cmd_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cur_row_out;
        logic [COL_W-1:0]  cur_col_out;
        logic [CUR_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } rsp_item_t;

    // Screen store port requests from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Linear position row*COLUMNS+col; col may equal COLUMNS
    function automatic logic [LIN_W-1:0] lin_pos(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W:0]   c);
        lin_pos = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
    endfunction

endpackage

// ===== rtl/core/tte_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tte_seq.sv =====
// Sequencer for the text terminal engine: cursor state, row fill lengths,
// attribute register, clear/scroll passes and screen store requests. Uses tte_pkg.
module tte_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tte_pkg::cmd_item_t                 cmd,
    output logic                               done,
    output tte_pkg::rsp_item_t                 rsp,
    input  logic                               cfg_we,
    input  logic [tte_pkg::ATTR_W-1:0]         cfg_wdata,
    output tte_pkg::ram_req_t                  ram_req,
    input  logic [tte_pkg::CELL_W-1:0]         ram_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK
    } state_t;

    localparam int AW = tte_pkg::ADDR_W;
    localparam int RW = tte_pkg::ROW_W;
    localparam int CW = tte_pkg::COL_W;
    localparam int UW = tte_pkg::CUR_W;
    localparam int LW = tte_pkg::LIN_W;
    localparam int FW = tte_pkg::FILL_IW;
    localparam int NR = tte_pkg::ROWS;

    localparam logic [AW-1:0] LAST_CELL  = AW'(tte_pkg::CELLS - 1);
    localparam logic [AW-1:0] COPY_END   = AW'(tte_pkg::CELLS - tte_pkg::COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(tte_pkg::COLUMNS);
    localparam logic [RW-1:0] LAST_ROW   = RW'(tte_pkg::ROWS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(tte_pkg::COLUMNS - 1);

    state_t                    state_reg, state_next;
    logic [RW-1:0]             row_reg, row_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [UW-1:0]             cursor_reg, cursor_next;
    logic [CW-1:0]             fill_reg [NR];
    logic [CW-1:0]             fill_next [NR];
    logic [tte_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [AW-1:0]             cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    tte_pkg::rsp_item_t        rsp_reg, rsp_next;

    // Position candidates
    logic [LW-1:0] put_lin, put_cur_lin, nl_lin, scroll_lin, bs_lin, rd_lin;
    logic [RW-1:0] bs_row;
    logic [CW-1:0] bs_col, bs_fill;
    logic [RW-1:0] prev_row;
    logic          rd_ok;

    assign prev_row    = row_reg - RW'(1);
    assign bs_fill     = fill_reg[prev_row[FW-1:0]];
    assign put_lin     = tte_pkg::lin_pos(row_reg, {1'b0, col_reg});
    assign put_cur_lin = tte_pkg::lin_pos(row_reg, {1'b0, col_reg} + (CW+1)'(1));
    assign nl_lin      = tte_pkg::lin_pos(row_reg + RW'(1), '0);
    assign scroll_lin  = tte_pkg::lin_pos(LAST_ROW, '0);
    assign rd_lin      = tte_pkg::lin_pos(cmd.read_row, {1'b0, cmd.read_col});
    assign rd_ok       = ({1'b0, cmd.read_row} < (RW+1)'(tte_pkg::ROWS))
                      && ({1'b0, cmd.read_col} < (CW+1)'(tte_pkg::COLUMNS));

    // Backspace target: step back, or return to the previous row's fill length
    always_comb
    begin
        if (col_reg == '0)
        begin
            bs_row = prev_row;
            bs_col = (bs_fill > LAST_COL) ? LAST_COL : bs_fill;
        end
        else
        begin
            bs_row = row_reg;
            bs_col = col_reg - CW'(1);
        end
    end
    assign bs_lin = tte_pkg::lin_pos(bs_row, {1'b0, bs_col});

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Next state, store requests and result
    always_comb
    begin
        logic do_scroll;
        logic emit;

        do_scroll   = 1'b0;
        emit        = 1'b0;
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cursor_next = cursor_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        attr_next   = cfg_we ? cfg_wdata : attr_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = put_lin[AW-1:0];
        ram_req.wdata = {attr_reg, cmd.char_code};
        ram_req.raddr = rd_lin[AW-1:0];

        case (state_reg)
            // Fill the store with blank cells after reset
            S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cnt_reg;
                ram_req.wdata = tte_pkg::BLANK_CELL;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        tte_pkg::FUNC_PUT:
                        begin
                            fill_next[row_reg[FW-1:0]] = col_reg;
                            if (cmd.char_code == tte_pkg::CH_NEWLINE)
                            begin
                                if (row_reg == LAST_ROW)
                                begin
                                    do_scroll = 1'b1;
                                end
                                else
                                begin
                                    row_next    = row_reg + RW'(1);
                                    col_next    = '0;
                                    cursor_next = nl_lin[UW-1:0];
                                    emit        = 1'b1;
                                end
                            end
                            else if (cmd.char_code == tte_pkg::CH_RETURN)
                            begin
                                col_next = '0;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                ram_req.we  = 1'b1;
                                cursor_next = put_cur_lin[UW-1:0];
                                if (col_reg == LAST_COL)
                                begin
                                    col_next = '0;
                                    if (row_reg == LAST_ROW)
                                    begin
                                        do_scroll = 1'b1;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + RW'(1);
                                        emit     = 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + CW'(1);
                                    emit     = 1'b1;
                                end
                            end
                        end

                        tte_pkg::FUNC_BKSP:
                        begin
                            emit = 1'b1;
                            if (!(col_reg == '0 && row_reg == '0))
                            begin
                                row_next      = bs_row;
                                col_next      = bs_col;
                                cursor_next   = bs_lin[UW-1:0];
                                ram_req.we    = 1'b1;
                                ram_req.waddr = bs_lin[AW-1:0];
                                ram_req.wdata = {attr_reg, tte_pkg::CH_NUL};
                            end
                        end

                        tte_pkg::FUNC_READ:
                        begin
                            if (rd_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end

                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase

                    // Enter the scroll pass: shift fill lengths, park at bottom row
                    if (do_scroll)
                    begin
                        for (int i = 0; i < NR - 1; i++)
                        begin
                            fill_next[i] = fill_next[i+1];
                        end
                        fill_next[NR-1] = '0;
                        row_next        = LAST_ROW;
                        col_next        = '0;
                        cursor_next     = scroll_lin[UW-1:0];
                        cnt_next        = '0;
                        state_next      = S_SCROLL;
                    end

                    if (emit)
                    begin
                        done_next            = 1'b1;
                        rsp_next.cur_row_out = row_next;
                        rsp_next.cur_col_out = col_next;
                        rsp_next.cursor_pos  = cursor_next;
                        rsp_next.cell_data   = '0;
                    end
                end
            end

            // Return the registered store word
            S_READ:
            begin
                state_next           = S_IDLE;
                done_next            = 1'b1;
                rsp_next.cur_row_out = row_reg;
                rsp_next.cur_col_out = col_reg;
                rsp_next.cursor_pos  = cursor_reg;
                rsp_next.cell_data   = ram_rdata;
            end

            // Copy each cell up one row: read one row ahead, write the word in the following cycle
            S_SCROLL:
            begin
                ram_req.raddr = cnt_reg + ROW_STRIDE;
                ram_req.waddr = cnt_reg - AW'(1);
                ram_req.wdata = ram_rdata;
                ram_req.we    = (cnt_reg != '0);
                if (cnt_reg == COPY_END)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            // Blank the bottom row in the current attribute
            S_BLANK:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cnt_reg;
                ram_req.wdata = {attr_reg, tte_pkg::CH_SPACE};
                if (cnt_reg == LAST_CELL)
                begin
                    state_next           = S_IDLE;
                    done_next            = 1'b1;
                    rsp_next.cur_row_out = row_reg;
                    rsp_next.cur_col_out = col_reg;
                    rsp_next.cursor_pos  = cursor_reg;
                    rsp_next.cell_data   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            row_reg    <= '0;
            col_reg    <= '0;
            cursor_reg <= '0;
            for (int i = 0; i < NR; i++)
            begin
                fill_reg[i] <= '0;
            end
            attr_reg   <= tte_pkg::ATTR_RESET;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            cursor_reg <= cursor_next;
            fill_reg   <= fill_next;
            attr_reg   <= attr_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            rsp_reg    <= rsp_next;
        end
    end

endmodule

// ===== rtl/core/text_terminal_engine.sv =====
// Top level of the text terminal engine: sequencer plus screen store RAM.
// Uses tte_pkg, tte_seq, tte_ram and text_terminal_engine_macros.svh.
//
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at a rising
//   edge with start high and busy low. func selects put character, backspace
//   or read one cell; func 3 does nothing but still answers.
//   Result channel: done pulses for one cycle with rsp holding row, column,
//   hardware cursor and read data. The receiver cannot stall; take it then.
//   Configuration: cfg_we with cfg_wdata writes the attribute byte used for
//   written cells; write only while the block is idle.
// Answers:
//   Put, backspace and out-of-range reads answer in the cycle after acceptance;
//   an in-range read first waits in S_READ for the store's registered read
//   port. A put that scrolls answers after a copy pass, one store word per
//   cycle through the single write port, and a pass that blanks the bottom
//   row. A new item may be taken in the cycle done is high.
// Reset:
//   rst_n resets the cursor, fill lengths and attribute at once, then a
//   clearing pass writes grey spaces into all CELLS = 2000 store words
//   while busy stays high.
module text_terminal_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tte_pkg::cmd_item_t         cmd,
    output logic                       done,
    output tte_pkg::rsp_item_t         rsp,
    input  logic                       cfg_we,
    input  logic [tte_pkg::ATTR_W-1:0] cfg_wdata
);

`include "text_terminal_engine_macros.svh"

    localparam logic [tte_pkg::ADDR_W-1:0] LAST_ADDR = tte_pkg::ADDR_W'(tte_pkg::CELLS - 1);
    localparam logic [tte_pkg::COL_W-1:0]  LAST_COL  = tte_pkg::COL_W'(tte_pkg::COLUMNS - 1);

    tte_pkg::ram_req_t                ram_req;
    logic [tte_pkg::CELL_W-1:0]       ram_rdata;

    // Command sequencing and cursor state
    tte_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Screen store
    tte_ram #(
        .WIDTH (tte_pkg::CELL_W),
        .DEPTH (tte_pkg::CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Checks
    `TTE_ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while busy")
    `TTE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted item stalled")
    `TTE_ASSERT_IMPL(a_wr_range, ram_req.we, ram_req.waddr <= LAST_ADDR, "store write out of range")
    `TTE_ASSERT_IMPL(a_col_range, done, rsp.cur_col_out <= LAST_COL, "column out of range")

endmodule

// ===== tb/text_terminal_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_terminal_engine: put, backspace, read and unused
// items run against a predictor of the screen store, cursor and row fill lengths.
// Depends on tte_pkg and the text_terminal_engine RTL.
module text_terminal_engine_tb;
    import tte_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SCROLL_BUDGET  = 60;
    localparam int PHASE_ITEMS    = 220;
    localparam int PHASES         = 5;
    localparam int REPORT_LIMIT   = 40;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    cmd_item_t         cmd       = '0;
    logic              done;
    rsp_item_t         rsp;
    logic              cfg_we    = 1'b0;
    logic [ATTR_W-1:0] cfg_wdata = '0;

    text_terminal_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted terminal state
    logic [CELL_W-1:0] screen_model [CELLS];
    logic [COL_W-1:0]  fill_model [ROWS];
    int                row_now;
    int                col_now;
    logic [CUR_W-1:0]  cursor_now;
    logic [ATTR_W-1:0] attr_now;

    // Items waiting to be driven and results still owed by the block
    cmd_item_t cmd_backlog [$];
    rsp_item_t due_results [$];
    rsp_item_t due;

    int idle_plan [PHASES]             = '{0, 46, 9, 0, 46};
    logic [ATTR_W-1:0] attr_plan [PHASES] = '{8'h00, 8'hFF, 8'h1E, 8'h00, 8'h07};
    int sender_idle_pct = 0;
    int phase_count     = 0;
    logic took          = 1'b0;
    int idle_cycles     = 0;
    int err_count       = 0;
    int results_seen    = 0;
    int scroll_count    = 0;
    int attr_writes     = 0;
    int put_count       = 0;
    int bksp_count      = 0;
    int read_count      = 0;
    int nop_count       = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shift the screen and fill lengths up one row and blank the bottom row
    function automatic void scroll_model();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (int i = 0; i < ROWS - 1; i++)
            fill_model[i] = fill_model[i + 1];
        fill_model[ROWS - 1] = '0;
        col_now    = 0;
        row_now    = ROWS - 1;
        cursor_now = CUR_W'(row_now * COLUMNS);
        for (int i = 0; i < COLUMNS; i++)
            screen_model[(ROWS - 1) * COLUMNS + i] = {attr_now, CH_SPACE};
        scroll_count++;
    endfunction

    // Advance the predicted terminal by one item and return its result
    function automatic rsp_item_t terminal_step(input cmd_item_t c);
        rsp_item_t         r;
        logic [CELL_W-1:0] data;
        data = '0;
        if (c.func == FUNC_PUT)
        begin
            fill_model[row_now] = COL_W'(col_now);
            if (c.char_code == CH_NEWLINE)
            begin
                if (row_now + 1 == ROWS)
                    scroll_model();
                else
                begin
                    row_now++;
                    col_now    = 0;
                    cursor_now = CUR_W'(row_now * COLUMNS);
                end
            end
            else if (c.char_code == CH_RETURN)
                col_now = 0;
            else
            begin
                screen_model[row_now * COLUMNS + col_now] = {attr_now, c.char_code};
                // cursor may point one past the last column until the wrap
                cursor_now = CUR_W'(row_now * COLUMNS + col_now + 1);
                col_now++;
                if (col_now == COLUMNS)
                begin
                    col_now = 0;
                    row_now++;
                    if (row_now == ROWS)
                        scroll_model();
                end
            end
        end
        else if (c.func == FUNC_BKSP)
        begin
            // nothing moves at the top left corner
            if (col_now != 0 || row_now != 0)
            begin
                if (col_now == 0)
                begin
                    row_now--;
                    col_now = fill_model[row_now];
                    if (col_now >= COLUMNS)
                        col_now = COLUMNS - 1;
                end
                else
                    col_now--;
                screen_model[row_now * COLUMNS + col_now] = {attr_now, CH_NUL};
                cursor_now = CUR_W'(row_now * COLUMNS + col_now);
            end
        end
        else if (c.func == FUNC_READ)
        begin
            if (c.read_row < ROWS && c.read_col < COLUMNS)
                data = screen_model[c.read_row * COLUMNS + c.read_col];
        end
        r.cur_row_out = ROW_W'(row_now);
        r.cur_col_out = COL_W'(col_now);
        r.cursor_pos  = cursor_now;
        r.cell_data   = data;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CELL_W-1:0] want,
                                        input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic queue_cmd(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        cmd_item_t c;
        c.func      = f;
        c.char_code = ch;
        c.read_row  = rr;
        c.read_col  = rc;
        cmd_backlog.push_back(c);
        phase_count++;
    endtask

    task automatic put_char_item(input logic [CHAR_W-1:0] ch);
        queue_cmd(FUNC_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    // Block until every queued item has been taken by the block
    task automatic drain_backlog();
        @(posedge clk);
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
    endtask

    task automatic wait_results();
        drain_backlog();
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the attribute register while the block is idle
    task automatic write_attr(input logic [ATTR_W-1:0] value);
        wait_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        attr_now = value;
        attr_writes++;
    endtask

    // A full line that wraps, enough newlines to scroll, then a line that
    // wraps off the bottom row
    task automatic queue_page();
        for (int i = 0; i <= COLUMNS; i++)
            put_char_item(CHAR_W'($urandom_range(32, 126)));
        for (int i = 0; i <= ROWS; i++)
            put_char_item(CH_NEWLINE);
        for (int i = 0; i < COLUMNS; i++)
            put_char_item(CHAR_W'($urandom_range(32, 126)));
    endtask

    // Pick a short run of items, steered by the current row so that scrolls
    // stay rare once their budget is spent
    task automatic plan_batch();
        int kind;
        int n;
        int roll;
        bit nl_ok;
        nl_ok = (row_now < ROWS - 1) ||
                (scroll_count < SCROLL_BUDGET && $urandom_range(0, 3) == 0);
        kind  = $urandom_range(0, 99);
        if (row_now == ROWS - 1 && scroll_count >= SCROLL_BUDGET && kind < 55)
            kind = 60;
        n = $urandom_range(4, 20);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // text with the odd line break
                if (roll < 4)
                    put_char_item(nl_ok ? CH_NEWLINE : CH_RETURN);
                else if (roll < 8)
                    put_char_item(CH_RETURN);
                else if (roll < 88)
                    put_char_item(CHAR_W'($urandom_range(32, 126)));
                else
                    put_char_item(CHAR_W'($urandom_range(0, 255)));
            end
            else if (kind < 55)
            begin
                if (roll < 50 && nl_ok)
                    put_char_item(CH_NEWLINE);
                else
                    put_char_item(CHAR_W'($urandom_range(32, 126)));
            end
            else if (kind < 75)
            begin
                // editing: mostly backspaces
                if (roll < 75)
                    queue_cmd(FUNC_BKSP, CHAR_W'($urandom), ROW_W'($urandom),
                              COL_W'($urandom));
                else
                    put_char_item(CHAR_W'($urandom_range(32, 126)));
            end
            else if (kind < 90)
            begin
                if (roll < 80)
                    queue_cmd(FUNC_READ, CHAR_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
                              COL_W'($urandom_range(0, COLUMNS - 1)));
                else
                    queue_cmd(FUNC_READ, CHAR_W'($urandom), ROW_W'($urandom),
                              COL_W'($urandom));
            end
            else
                queue_cmd(FUNC_W'($urandom), CHAR_W'($urandom), ROW_W'($urandom),
                          COL_W'($urandom));
        end
    endtask

    // Driver: present the next item at the falling edge, hold it until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                cmd   <= cmd_backlog.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check results, predict each accepted item
    always @(posedge clk)
    begin
        took <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, got %h", $time, rsp);
                end
                else
                begin
                    due = due_results.pop_front();
                    check_field("cur_row_out", due.cur_row_out, rsp.cur_row_out);
                    check_field("cur_col_out", due.cur_col_out, rsp.cur_col_out);
                    check_field("cursor_pos", due.cursor_pos, rsp.cursor_pos);
                    check_field("cell_data", due.cell_data, rsp.cell_data);
                    results_seen++;
                end
            end
            if (start && !busy)
            begin
                due_results.push_back(terminal_step(cmd));
                case (cmd.func)
                    FUNC_PUT:  put_count++;
                    FUNC_BKSP: bksp_count++;
                    FUNC_READ: read_count++;
                    default:   nop_count++;
                endcase
            end
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_terminal_engine_tb failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = BLANK_CELL;
        for (int i = 0; i < ROWS; i++)
            fill_model[i] = '0;
        row_now    = 0;
        col_now    = 0;
        cursor_now = '0;
        attr_now   = ATTR_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: read extremes, unused func, corner backspace, line handling
        queue_cmd(FUNC_READ, 8'h00, 5'd0, 7'd0);
        queue_cmd(FUNC_READ, 8'hFF, 5'd31, 7'd127);
        queue_cmd(FUNC_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        queue_cmd(FUNC_READ, 8'h00, ROW_W'(ROWS), 7'd0);
        queue_cmd(FUNC_READ, 8'h00, 5'd0, COL_W'(COLUMNS));
        queue_cmd(FUNC_NOP, 8'hFF, 5'd31, 7'd127);
        queue_cmd(FUNC_BKSP, 8'h00, 5'd0, 7'd0);
        put_char_item(8'h41);
        put_char_item(8'h00);
        put_char_item(8'hFF);
        put_char_item(CH_RETURN);
        put_char_item(8'h42);
        put_char_item(CH_NEWLINE);
        queue_cmd(FUNC_BKSP, 8'hFF, 5'd31, 7'd127);
        queue_cmd(FUNC_BKSP, 8'h00, 5'd0, 7'd0);
        put_char_item(CH_NEWLINE);
        put_char_item(CH_NEWLINE);
        put_char_item(8'h7F);
        put_char_item(8'h80);
        put_char_item(8'h55);
        put_char_item(8'hAA);
        queue_cmd(FUNC_READ, 8'h00, 5'd0, 7'd0);
        queue_cmd(FUNC_READ, 8'h00, 5'd0, 7'd1);
        queue_cmd(FUNC_NOP, 8'h00, 5'd0, 7'd0);

        // Random phases, each with an attribute write and a sender idling level
        for (int p = 0; p < PHASES; p++)
        begin
            write_attr(p == 3 ? ATTR_W'($urandom) : attr_plan[p]);
            sender_idle_pct = idle_plan[p];
            phase_count     = 0;
            if (p == 0 || p == 3)
                queue_page();
            while (phase_count < PHASE_ITEMS)
            begin
                drain_backlog();
                plan_batch();
            end
        end

        wait_results();
        repeat (10) @(posedge clk);
        err_count += due_results.size();
        $display("Run covered %0d puts, %0d backspaces, %0d reads, %0d unused items, %0d scrolls",
                 put_count, bksp_count, read_count, nop_count, scroll_count);
        $display("%0d results checked across %0d attribute settings", results_seen, attr_writes);
        if (err_count == 0)
            $display("text_terminal_engine_tb passed");
        else
            $display("text_terminal_engine_tb failed");
        $finish;
    end

endmodule
